### src/lsb_stego_stream_extractor_assert.svh
// Assertion macros for the LSB stego stream extractor.
// No dependencies; include in files that carry concurrent checks.
// Each check is clocked on clk_i and disabled while rst_ni is low.
`ifndef LSB_STEGO_STREAM_EXTRACTOR_ASSERT_SVH
`define LSB_STEGO_STREAM_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define LSBSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LSBSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LSBSE_ASSERT(lbl, prop, msg)
`define LSBSE_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

### src/lsbse_pkg.sv
// Package for the LSB stego stream extractor: parse phases, result kinds,
// register indexes and fixed constants. No dependencies.
`default_nettype none

package lsbse_pkg;

  // Longest extension string accepted before flagging an error.
  localparam logic [31:0] MAX_EXT_LEN = 32'd16;
  // Signature bytes are capped at this count.
  localparam logic [3:0]  MAGIC_MAX   = 4'd8;
  // Length fields are four hidden bytes, big-endian.
  localparam logic [31:0] LEN_BYTES   = 32'd4;

  localparam logic [7:0]  HEADER_LEN_RST = 8'd54;
  localparam logic [3:0]  MAGIC_LEN_RST  = 4'd2;
  localparam logic [63:0] MAGIC_VAL_RST  = 64'd8995;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_MAGIC  = 3'd1,
    PH_EXTLEN = 3'd2,
    PH_EXT    = 3'd3,
    PH_PAYLEN = 3'd4,
    PH_PAY    = 3'd5,
    PH_HALT   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_EXT       = 3'd0,
    KIND_PAY       = 3'd1,
    KIND_MAGIC_ERR = 3'd2,
    KIND_EXT_LONG  = 3'd3,
    KIND_EMPTY     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CFG_HEADER_LEN = 2'd0,
    CFG_MAGIC_LEN  = 2'd1,
    CFG_MAGIC_VAL  = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

### src/lsbse_if.sv
// Stream interfaces for the LSB stego stream extractor: image byte beats in,
// decoded result beats out. Depends on lsbse_pkg.
`default_nettype none

interface lsbse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;
  logic       new_image;

  modport source (output valid, output image_byte, output new_image, input ready);
  modport sink   (input valid, input image_byte, input new_image, output ready);
endinterface

interface lsbse_out_if import lsbse_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] hidden_byte;
  kind_e      kind;
  logic       last;

  modport source (output valid, output hidden_byte, output kind, output last, input ready);
  modport sink   (input valid, input hidden_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

### src/lsb_stego_stream_extractor.sv
// LSB stego stream extractor top level: parse state, result register and
// config registers. Depends on lsbse_pkg, lsbse_if and the assertion header.
//
//   Port         Dir   Content                         Handshake
//   img_i        in    image_byte[7:0], new_image      valid / ready
//   res_o        out   hidden_byte[7:0], kind, last    valid / ready
//   cfg_*_i      in    idx[1:0], wdata[63:0]           cfg_we_i, no wait
//
// One image byte per cycle while img_i.ready is high; the parse state updates
// at the edge that takes the beat; the result register drives res_o next cycle.
// img_i.ready drops only while a result sits in the register and res_o.ready is
// low; that register is the only thing that stalls the input side.
// Reset loads the register defaults and starts in header skip with no result.
`default_nettype none
`include "lsb_stego_stream_extractor_assert.svh"

module lsb_stego_stream_extractor import lsbse_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  lsbse_in_if.sink    img_i,
  lsbse_out_if.source res_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [63:0] cfg_wdata_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [7:0]  header_len_q;
  logic [3:0]  magic_len_q;
  logic [63:0] magic_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_len_q <= HEADER_LEN_RST;
      magic_len_q  <= MAGIC_LEN_RST;
      magic_val_q  <= MAGIC_VAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER_LEN: header_len_q <= cfg_wdata_i[7:0];
        CFG_MAGIC_LEN:  magic_len_q  <= cfg_wdata_i[3:0];
        CFG_MAGIC_VAL:  magic_val_q  <= cfg_wdata_i;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------
  phase_e      phase_q, phase_d;
  logic [7:0]  skip_q, skip_d;
  logic [2:0]  bit_cnt_q, bit_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [31:0] fcnt_q, fcnt_d;
  logic [31:0] accum_q, accum_d;
  logic [31:0] flen_q, flen_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  kind_e       out_kind_q;
  logic        out_last_q;

  logic in_take;
  assign img_i.ready = !out_valid_q || res_o.ready;
  assign in_take     = img_i.valid && img_i.ready;

  // ---------------------------------------------------------------------
  // Front end: apply a restart, then decide header skip or data bit
  // ---------------------------------------------------------------------
  logic        restart;
  phase_e      cur_phase;
  logic [7:0]  cur_skip;
  logic [2:0]  cur_bit;
  logic [7:0]  cur_shift;
  logic [31:0] cur_fcnt, cur_accum, cur_flen;
  logic [3:0]  mlen;
  logic        hdr_skip;
  phase_e      eff_phase;
  logic [31:0] eff_fcnt, eff_accum;
  logic        active;
  logic        byte_done;
  logic [7:0]  hidden;
  logic [31:0] fcnt_inc;
  logic [31:0] accum_new;
  logic [2:0]  magic_sel;
  logic [7:0]  magic_want;
  logic        magic_bad;
  logic        len_done;
  logic        field_last;

  assign restart   = img_i.new_image;
  assign cur_phase = restart ? PH_HEADER : phase_q;
  assign cur_skip  = restart ? 8'd0  : skip_q;
  assign cur_bit   = restart ? 3'd0  : bit_cnt_q;
  assign cur_shift = restart ? 8'd0  : shift_q;
  assign cur_fcnt  = restart ? 32'd0 : fcnt_q;
  assign cur_accum = restart ? 32'd0 : accum_q;
  assign cur_flen  = restart ? 32'd0 : flen_q;

  assign mlen     = (magic_len_q > MAGIC_MAX) ? MAGIC_MAX : magic_len_q;
  assign hdr_skip = (cur_phase == PH_HEADER) && (cur_skip < header_len_q);

  // Leaving the header: the same beat already carries the first data bit.
  always_comb begin
    eff_phase = cur_phase;
    eff_fcnt  = cur_fcnt;
    eff_accum = cur_accum;
    if (cur_phase == PH_HEADER) begin
      eff_phase = (mlen == 4'd0) ? PH_EXTLEN : PH_MAGIC;
      eff_fcnt  = 32'd0;
      eff_accum = 32'd0;
    end
  end

  assign active = !hdr_skip &&
                  (eff_phase == PH_MAGIC || eff_phase == PH_EXTLEN ||
                   eff_phase == PH_EXT   || eff_phase == PH_PAYLEN ||
                   eff_phase == PH_PAY);
  assign hidden    = {cur_shift[6:0], img_i.image_byte[0]};
  assign byte_done = (cur_bit == 3'd7);
  assign fcnt_inc  = eff_fcnt + 32'd1;
  assign accum_new = {eff_accum[23:0], hidden};

  // Signature byte select wraps mod 8, as the shift amount does.
  assign magic_sel  = mlen[2:0] - 3'd1 - eff_fcnt[2:0];
  assign magic_want = magic_val_q[{magic_sel, 3'b000} +: 8];
  assign magic_bad  = (hidden != magic_want);
  assign len_done   = (fcnt_inc >= LEN_BYTES);
  assign field_last = (fcnt_inc == cur_flen);

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    bit_cnt_d = bit_cnt_q;
    shift_d   = shift_q;
    fcnt_d    = fcnt_q;
    accum_d   = accum_q;
    flen_d    = flen_q;
    if (in_take) begin
      skip_d    = cur_skip;
      bit_cnt_d = cur_bit;
      shift_d   = cur_shift;
      flen_d    = cur_flen;
      if (hdr_skip) begin
        phase_d = PH_HEADER;
        skip_d  = cur_skip + 8'd1;
        fcnt_d  = cur_fcnt;
        accum_d = cur_accum;
      end else begin
        phase_d = eff_phase;
        fcnt_d  = eff_fcnt;
        accum_d = eff_accum;
        if (active) begin
          if (!byte_done) begin
            bit_cnt_d = cur_bit + 3'd1;
            shift_d   = hidden;
          end else begin
            bit_cnt_d = 3'd0;
            shift_d   = 8'd0;
            unique case (eff_phase)
              PH_MAGIC: begin
                if (magic_bad) begin
                  phase_d = PH_HALT;
                end else if (fcnt_inc >= {28'd0, mlen}) begin
                  fcnt_d  = 32'd0;
                  accum_d = 32'd0;
                  phase_d = PH_EXTLEN;
                end else begin
                  fcnt_d = fcnt_inc;
                end
              end
              PH_EXTLEN, PH_PAYLEN: begin
                if (!len_done) begin
                  fcnt_d  = fcnt_inc;
                  accum_d = accum_new;
                end else begin
                  flen_d  = accum_new;
                  fcnt_d  = 32'd0;
                  accum_d = 32'd0;
                  if (eff_phase == PH_EXTLEN) begin
                    if (accum_new > MAX_EXT_LEN) phase_d = PH_HALT;
                    else if (accum_new == 32'd0) phase_d = PH_PAYLEN;
                    else phase_d = PH_EXT;
                  end else begin
                    phase_d = (accum_new == 32'd0) ? PH_HALT : PH_PAY;
                  end
                end
              end
              PH_EXT, PH_PAY: begin
                if (field_last) begin
                  fcnt_d  = 32'd0;
                  accum_d = 32'd0;
                  phase_d = (eff_phase == PH_EXT) ? PH_PAYLEN : PH_HALT;
                end else begin
                  fcnt_d = fcnt_inc;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result decode
  // ---------------------------------------------------------------------
  logic       res_valid;
  logic [7:0] res_byte;
  kind_e      res_kind;
  logic       res_last;

  always_comb begin
    res_valid = 1'b0;
    res_byte  = 8'd0;
    res_kind  = KIND_EXT;
    res_last  = 1'b0;
    if (active && byte_done) begin
      unique case (eff_phase)
        PH_MAGIC: begin
          if (magic_bad) begin
            res_valid = 1'b1;
            res_kind  = KIND_MAGIC_ERR;
          end
        end
        PH_EXTLEN: begin
          if (len_done && accum_new > MAX_EXT_LEN) begin
            res_valid = 1'b1;
            res_kind  = KIND_EXT_LONG;
          end
        end
        PH_PAYLEN: begin
          if (len_done && accum_new == 32'd0) begin
            res_valid = 1'b1;
            res_kind  = KIND_EMPTY;
          end
        end
        PH_EXT, PH_PAY: begin
          res_valid = 1'b1;
          res_byte  = hidden;
          res_kind  = (eff_phase == PH_EXT) ? KIND_EXT : KIND_PAY;
          res_last  = field_last;
        end
        default: ;
      endcase
    end
  end

  // Load a new result with each beat taken; clear once the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_take) out_valid_d = res_valid;
    else if (res_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      skip_q      <= 8'd0;
      bit_cnt_q   <= 3'd0;
      shift_q     <= 8'd0;
      fcnt_q      <= 32'd0;
      accum_q     <= 32'd0;
      flen_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      skip_q      <= skip_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      fcnt_q      <= fcnt_d;
      accum_q     <= accum_d;
      flen_q      <= flen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && res_valid) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.hidden_byte = out_byte_q;
  assign res_o.kind        = out_kind_q;
  assign res_o.last        = out_last_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `LSBSE_ASSERT_IMPL(a_no_overrun, out_valid_q && !res_o.ready, !img_i.ready,
    "input taken while result register is blocked")
  `LSBSE_ASSERT_IMPL(a_hdr_no_bits, phase_q == PH_HEADER,
    bit_cnt_q == 3'd0 && shift_q == 8'd0, "bit gather active during header skip")
  `LSBSE_ASSERT_IMPL(a_ext_len_ok, phase_q == PH_EXT,
    flen_q != 32'd0 && flen_q <= MAX_EXT_LEN, "extension phase with bad length")
  `LSBSE_ASSERT_IMPL(a_status_clean,
    out_valid_q && (out_kind_q == KIND_MAGIC_ERR || out_kind_q == KIND_EXT_LONG ||
                    out_kind_q == KIND_EMPTY),
    out_byte_q == 8'd0 && !out_last_q, "status result carries data")

endmodule

`default_nettype wire

### tb/lsbse_decode_checker.sv
`timescale 1ns / 1ps
// Result checker for the LSB stego stream extractor: predicts decoded results
// from accepted image beats and compares them with the result channel.
// Depends on lsbse_pkg and the stream interfaces in lsbse_if.
module lsbse_decode_checker import lsbse_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  lsbse_in_if         img_mon,
  lsbse_out_if        res_mon,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [63:0] cfg_wdata_i,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned checked_count
);

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } decoded_t;

  decoded_t    decoded_q[$];

  // Shadow of the register file.
  logic [7:0]  hdr_len_reg;
  logic [3:0]  magic_len_reg;
  logic [63:0] magic_val_reg;

  // Shadow of the parse state.
  phase_e      parse_st;
  logic [7:0]  hdr_seen;
  logic [2:0]  bit_idx;
  logic [7:0]  lsb_shreg;
  logic [31:0] fld_idx;
  logic [31:0] len_acc;
  logic [31:0] fld_len;

  function automatic void clear_parse();
    parse_st  = PH_HEADER;
    hdr_seen  = '0;
    bit_idx   = '0;
    lsb_shreg = '0;
    fld_idx   = '0;
    len_acc   = '0;
    fld_len   = '0;
  endfunction

  function automatic logic [3:0] magic_bytes();
    return (magic_len_reg > MAGIC_MAX) ? MAGIC_MAX : magic_len_reg;
  endfunction

  // Consume one recovered hidden byte; return 1 when it yields a result.
  function automatic bit take_hidden(input logic [7:0] hb, inout decoded_t r);
    logic [5:0] sh;
    logic [7:0] want;
    case (parse_st)
      PH_MAGIC: begin
        sh   = 6'((32'(magic_bytes()) - 32'd1 - fld_idx) << 3);
        want = 8'(magic_val_reg >> sh);
        if (hb != want) begin
          parse_st = PH_HALT;
          r.kind   = KIND_MAGIC_ERR;
          return 1'b1;
        end
        fld_idx++;
        if (fld_idx >= 32'(magic_bytes())) begin
          fld_idx  = '0;
          len_acc  = '0;
          parse_st = PH_EXTLEN;
        end
        return 1'b0;
      end
      PH_EXTLEN, PH_PAYLEN: begin
        len_acc = {len_acc[23:0], hb};
        fld_idx++;
        if (fld_idx < LEN_BYTES) return 1'b0;
        fld_len = len_acc;
        fld_idx = '0;
        len_acc = '0;
        if (parse_st == PH_EXTLEN) begin
          if (fld_len > MAX_EXT_LEN) begin
            parse_st = PH_HALT;
            r.kind   = KIND_EXT_LONG;
            return 1'b1;
          end
          parse_st = (fld_len == 0) ? PH_PAYLEN : PH_EXT;
          return 1'b0;
        end
        if (fld_len == 0) begin
          parse_st = PH_HALT;
          r.kind   = KIND_EMPTY;
          return 1'b1;
        end
        parse_st = PH_PAY;
        return 1'b0;
      end
      PH_EXT, PH_PAY: begin
        r.kind = (parse_st == PH_EXT) ? KIND_EXT : KIND_PAY;
        r.data = hb;
        r.last = (fld_idx + 32'd1 == fld_len);
        fld_idx++;
        if (r.last) begin
          fld_idx  = '0;
          len_acc  = '0;
          parse_st = (parse_st == PH_EXT) ? PH_PAYLEN : PH_HALT;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Advance the shadow parser by one image beat.
  function automatic bit extract_beat(input logic [7:0] ib, input logic restart,
                                      output decoded_t r);
    logic [7:0] hb;
    r = '{data: 8'd0, kind: KIND_EXT, last: 1'b0};
    if (restart) clear_parse();
    if (parse_st == PH_HEADER) begin
      if (hdr_seen < hdr_len_reg) begin
        hdr_seen++;
        return 1'b0;
      end
      parse_st = (magic_bytes() == 0) ? PH_EXTLEN : PH_MAGIC;
      fld_idx  = '0;
      len_acc  = '0;
    end
    if (parse_st == PH_HALT) return 1'b0;
    lsb_shreg = {lsb_shreg[6:0], ib[0]};
    if (bit_idx < 3'd7) begin
      bit_idx++;
      return 1'b0;
    end
    bit_idx   = '0;
    hb        = lsb_shreg;
    lsb_shreg = '0;
    return take_hidden(hb, r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    decoded_t pred;
    decoded_t want;
    if (!rst_ni) begin
      hdr_len_reg   = HEADER_LEN_RST;
      magic_len_reg = MAGIC_LEN_RST;
      magic_val_reg = MAGIC_VAL_RST;
      clear_parse();
      decoded_q.delete();
      fail_count    = 0;
      checked_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_HEADER_LEN: hdr_len_reg   = cfg_wdata_i[7:0];
          CFG_MAGIC_LEN:  magic_len_reg = cfg_wdata_i[3:0];
          CFG_MAGIC_VAL:  magic_val_reg = cfg_wdata_i;
          default: ;
        endcase
      end
      if (img_mon.valid && img_mon.ready) begin
        if (extract_beat(img_mon.image_byte, img_mon.new_image, pred))
          decoded_q.push_back(pred);
      end
      if (res_mon.valid && res_mon.ready) begin
        checked_count++;
        if (decoded_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none, got byte %02h kind %0d last %0b",
                   $time, res_mon.hidden_byte, res_mon.kind, res_mon.last);
        end else begin
          want = decoded_q.pop_front();
          if (res_mon.hidden_byte !== want.data) begin
            fail_count++;
            $display("%0t hidden_byte mismatch: expected %02h, got %02h",
                     $time, want.data, res_mon.hidden_byte);
          end
          if (res_mon.kind !== want.kind) begin
            fail_count++;
            $display("%0t kind mismatch: expected %0d, got %0d",
                     $time, want.kind, res_mon.kind);
          end
          if (res_mon.last !== want.last) begin
            fail_count++;
            $display("%0t last mismatch: expected %0b, got %0b",
                     $time, want.last, res_mon.last);
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

### tb/tb_lsb_stego_stream_extractor.sv
`timescale 1ns / 1ps
// Top of the LSB stego stream extractor testbench: clock, reset, image beat
// stimulus, result back-pressure and the verdict. Depends on lsbse_pkg,
// lsbse_if, the extractor RTL and lsbse_decode_checker.
module tb_lsb_stego_stream_extractor import lsbse_pkg::*; ();

  localparam int unsigned RANDOM_BEATS = 160;     // image beats in the random part
  localparam int unsigned RANDOM_SETS  = 2;       // register settings in the random part
  localparam int unsigned HOLD_CYCLES  = 600;     // one long result-side hold-off
  localparam int unsigned SETTLE       = 6;       // results pass one result register; pad it
  localparam int unsigned PAYLOAD_CAP  = 64;      // never build more payload bytes than this
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;

  lsbse_in_if  img_if ();
  lsbse_out_if res_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked_count;

  // Stimulus-side knobs. Only the stimulus process writes idle_pct and hold_req.
  int unsigned idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;   // written by the receiver only

  // Stimulus view of the registers, used to build well-formed images.
  logic [7:0]  cur_hdr   = HEADER_LEN_RST;
  logic [3:0]  cur_mlen  = MAGIC_LEN_RST;   // already capped at MAGIC_MAX
  logic [63:0] cur_magic = MAGIC_VAL_RST;

  bit [7:0]    hidden_q[$];        // hidden bytes of the image being sent
  int unsigned beats_sent  = 0;
  int unsigned images_sent = 0;
  int unsigned settings    = 1;    // the reset setting counts
  int unsigned cycle_count = 0;

  lsb_stego_stream_extractor u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .img_i       (img_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  lsbse_decode_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .img_mon       (img_if),
    .res_mon       (res_if),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if it has not finished by the cycle limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t timeout with %0d results still expected", $time, pending);
    $display("tb: failure");
    $finish;
  end

  // Result side: random ready bursts, one long hold-off on request, and a
  // steady ready while idling is switched off.
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        // Hold off long enough for the result register to fill and the
        // image side to stall while beats keep being offered.
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Offer one image beat and hold it until the block takes it. Ready is
  // sampled at the falling edge, where nothing is changing.
  task automatic send_beat(input logic [7:0] ib, input logic restart);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      img_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    img_if.valid      <= 1'b1;
    img_if.image_byte <= ib;
    img_if.new_image  <= restart;
    @(negedge clk_i);
    while (!img_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    beats_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain();
    img_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write all three registers back to back; junk in the unused upper bits
  // must be dropped by the block.
  task automatic program_regs(input logic [7:0] hdr, input logic [3:0] mlen,
                              input logic [63:0] magic);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HEADER_LEN;
    cfg_wdata_i <= {56'({$urandom, $urandom}), hdr};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAGIC_LEN;
    cfg_wdata_i <= {60'({$urandom, $urandom}), mlen};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MAGIC_VAL;
    cfg_wdata_i <= magic;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_hdr   = hdr;
    cur_mlen  = (mlen > MAGIC_MAX) ? MAGIC_MAX : mlen;
    cur_magic = magic;
    settings++;
  endtask

  // Lay out the hidden stream: signature, extension length and characters,
  // payload length and payload. Stop after a length that ends the parse.
  task automatic build_stream(input logic [31:0] ext_len, input logic [31:0] pay_len,
                              input int bad_at);
    hidden_q.delete();
    for (int i = 0; i < int'(cur_mlen); i++)
      hidden_q.push_back(cur_magic[8 * (int'(cur_mlen) - 1 - i) +: 8]);
    if (bad_at >= 0 && bad_at < int'(cur_mlen))
      hidden_q[bad_at] ^= 8'($urandom_range(1, 255));
    for (int i = 3; i >= 0; i--) hidden_q.push_back(ext_len[8 * i +: 8]);
    if (ext_len > MAX_EXT_LEN) return;
    for (int i = 0; i < int'(ext_len); i++) hidden_q.push_back(8'($urandom));
    for (int i = 3; i >= 0; i--) hidden_q.push_back(pay_len[8 * i +: 8]);
    for (int i = 0; i < int'(pay_len) && i < int'(PAYLOAD_CAP); i++)
      hidden_q.push_back(8'($urandom));
  endtask

  // Cut the hidden stream short, to break an image off mid-parse.
  task automatic truncate_stream(input int unsigned keep);
    while (hidden_q.size() > keep) void'(hidden_q.pop_back());
  endtask

  // Send header bytes, then each hidden bit MSB first in bit 0 of an image
  // byte with random upper bits, then trailing bytes.
  task automatic send_image(input int unsigned hdr_beats, input bit restart,
                            input int unsigned junk);
    bit first;
    first = restart;
    for (int unsigned k = 0; k < hdr_beats; k++) begin
      send_beat(8'($urandom), first);
      first = 1'b0;
    end
    foreach (hidden_q[i]) begin
      for (int j = 7; j >= 0; j--) begin
        send_beat({7'($urandom), hidden_q[i][j]}, first);
        first = 1'b0;
      end
    end
    for (int unsigned k = 0; k < junk; k++) send_beat(8'($urandom), 1'b0);
    images_sent++;
  endtask

  // Mostly well-formed images with random content; the rest are broken
  // signatures, over-long extensions, empty payloads, cut-off images, noise.
  task automatic send_random_image();
    int unsigned pick;
    logic [31:0] ext_len;
    logic [31:0] pay_len;
    int          bad_at;
    pick    = $urandom_range(0, 99);
    ext_len = ($urandom_range(0, 9) == 0) ? MAX_EXT_LEN : 32'($urandom_range(0, 4));
    pay_len = 32'($urandom_range(1, 8));
    bad_at  = -1;
    if (pick >= 62 && pick < 72 && cur_mlen != 0)
      bad_at = $urandom_range(0, int'(cur_mlen) - 1);
    else if (pick >= 72 && pick < 78)
      ext_len = ($urandom_range(0, 1) == 1) ? MAX_EXT_LEN + 32'($urandom_range(1, 40))
                                            : ($urandom | 32'h8000_0000);
    else if (pick >= 78 && pick < 84)
      pay_len = '0;
    else if (pick >= 84 && pick < 92 && $urandom_range(0, 1) == 1)
      pay_len = $urandom;
    build_stream(ext_len, pay_len, bad_at);
    if (pick >= 84 && pick < 92)
      truncate_stream($urandom_range(0, hidden_q.size()));
    if (pick >= 92) begin
      hidden_q.delete();
      repeat ($urandom_range(2, 8)) hidden_q.push_back(8'($urandom));
    end
    send_image(cur_hdr, 1'b1, $urandom_range(0, 4));
  endtask

  initial begin
    int unsigned quota_start;
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_HEADER_LEN;
    cfg_wdata_i       <= '0;
    img_if.valid      <= 1'b0;
    img_if.image_byte <= '0;
    img_if.new_image  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: 54 header bytes, two-byte "##"-style signature.
    idle_pct = 15;
    build_stream(32'd1, 32'd2, -1);          // break off mid-signature ...
    truncate_stream(1);
    send_image(cur_hdr, 1'b1, 0);
    build_stream(32'd2, 32'd1, -1);          // ... restart: short extension, one payload byte
    send_image(cur_hdr, 1'b1, 3);
    // Stop partway through the header, then shrink the header below the
    // count already skipped; the next beat must open the signature. An
    // oversized signature length must cap at eight.
    hidden_q.delete();
    send_image(20, 1'b1, 0);
    drain();
    program_regs(8'd3, 4'd15, 64'd0);
    build_stream(32'd0, 32'd1, -1);          // empty extension
    send_image(0, 1'b0, 2);
    build_stream(32'd0, 32'd1, 7);           // signature wrong only in its last byte
    truncate_stream(8);
    send_image(cur_hdr, 1'b1, 0);
    drain();

    // No header, no signature: data starts on the restart beat itself.
    program_regs(8'd0, 4'd0, 64'd0);
    build_stream(MAX_EXT_LEN + 1, 32'd1, -1); // extension one over the limit
    send_image(cur_hdr, 1'b1, 2);
    // Longest legal extension, then an empty payload. Hold the result side
    // off meanwhile so the result register fills and the image side stalls.
    hold_req = 1'b1;
    build_stream(MAX_EXT_LEN, 32'd0, -1);
    send_image(cur_hdr, 1'b1, 2);
    build_stream(32'hFFFF_FFFF, 32'd1, -1);  // all-ones extension length
    send_image(cur_hdr, 1'b1, 1);
    drain();

    // Random part: RANDOM_SETS register settings, the last one with no idling.
    for (int unsigned p = 0; p < RANDOM_SETS; p++) begin
      program_regs(($urandom_range(0, 7) == 0) ? HEADER_LEN_RST : 8'($urandom_range(0, 12)),
                   4'($urandom_range(0, 15)), {$urandom, $urandom});
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      if (p == RANDOM_SETS - 1) idle_pct = 0;
      quota_start = beats_sent;
      while (beats_sent - quota_start < RANDOM_BEATS / RANDOM_SETS)
        send_random_image();
      drain();
    end

    @(negedge clk_i);
    $display("summary: %0d image beats in %0d images over %0d register settings",
             beats_sent, images_sent, settings);
    $display("summary: %0d results checked, %0d mismatches", checked_count, fail_count);
    if (pending != 0)
      $display("%0t %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/lsbse_pkg.sv
src/lsbse_if.sv
src/lsb_stego_stream_extractor.sv
tb/lsbse_decode_checker.sv
tb/tb_lsb_stego_stream_extractor.sv
